>>> hw/rtl/aels_pkg.sv
// ----------------------------------------------------------------------------
// aels_pkg: shared types and constants for the exposure level stepper
// Register indexes, reset values and the loop state struct.
// ----------------------------------------------------------------------------
package aels_pkg;

	localparam int LumaW  = 8;
	localparam int LevelW = 8;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 8;

	typedef logic [LumaW-1:0]  luma_t;
	typedef logic [LevelW-1:0] level_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET_LUMA = 1'b0,
		REG_MAX_LEVEL   = 1'b1
	} cfg_reg_t;

	localparam luma_t  TargetLumaRst = 8'd64;
	localparam level_t MaxLevelRst   = 8'd127;
	localparam luma_t  PrevLumaRst   = 8'd60;
	localparam level_t LevelRst      = 8'd80;

	// Smoothing and stepping thresholds.
	localparam luma_t JumpLimit = 8'd20;
	localparam luma_t HoldBand  = 8'd6;
	localparam luma_t MoveBand  = 8'd4;
	localparam luma_t Band1     = 8'd10;
	localparam luma_t Band2     = 8'd20;
	localparam luma_t Band3     = 8'd30;
	localparam luma_t Band4     = 8'd40;
	localparam logic [1:0] RoundBias = 2'd2;

	typedef struct packed {
		level_t level;
		logic   stable;
	} loop_state_t;

endpackage

>>> hw/rtl/aels_in_if.sv
// ----------------------------------------------------------------------------
// aels_in_if: frame luma channel
// Valid/ready channel carrying one mean luma word per frame.
// ----------------------------------------------------------------------------
interface aels_in_if;
	logic               valid;
	logic               ready;
	aels_pkg::luma_t    frame_luma;

	modport source (output valid, output frame_luma, input ready);
	modport sink   (input valid, input frame_luma, output ready);
endinterface

>>> hw/rtl/aels_out_if.sv
// ----------------------------------------------------------------------------
// aels_out_if: exposure result channel
// Valid/ready channel carrying smoothed luma, level index and stable flag.
// ----------------------------------------------------------------------------
interface aels_out_if;
	logic               valid;
	logic               ready;
	aels_pkg::luma_t    smoothed_luma;
	aels_pkg::level_t   exposure_level;
	logic               is_stable;

	modport source (output valid, output smoothed_luma, output exposure_level,
		output is_stable, input ready);
	modport sink   (input valid, input smoothed_luma, input exposure_level,
		input is_stable, output ready);
endinterface

>>> hw/rtl/auto_exposure_level_stepper_core.sv
// ----------------------------------------------------------------------------
// auto_exposure_level_stepper_core: auto-exposure level stepper
// Smooths each frame mean luma and steps an exposure level toward target.
// ----------------------------------------------------------------------------
//  channel     dir  word contents
//  luma        in   frame_luma
//  result      out  smoothed_luma, exposure_level, is_stable
//  cfg_*       in   register write: target_luma (0), max_level (1)
//
// One word per cycle sustained while the result is taken. A word waits in the input register,
// and the smoothing and step logic load the loop state, which is also the
// result register, from it: the result is valid once that load is made, and
// a stalled result holds the word in the input register until it is taken.
// Reset clears all valid flags and loads the loop state reset values.
// A stalled result holds the input register; input ready drops only when both
// the input register and the result register are full and the result is stalled.
module auto_exposure_level_stepper_core (
	input  logic                          clk,
	input  logic                          arst_n,
	aels_in_if.sink                       luma,
	aels_out_if.source                    result,
	input  logic                          cfg_we,
	input  logic [aels_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [aels_pkg::CfgDataW-1:0] cfg_wdata
);

	aels_pkg::luma_t       target_luma;
	aels_pkg::level_t      max_level;

	logic                  valid_s1;
	aels_pkg::luma_t       luma_s1;
	logic                  out_valid_q;
	aels_pkg::luma_t       prev_luma_q;
	aels_pkg::loop_state_t state_q;

	aels_pkg::luma_t       smoothed;
	aels_pkg::loop_state_t state_nxt;
	logic                  advance;

	aels_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.target_luma (target_luma),
		.max_level   (max_level)
	);

	aels_smooth u_smooth (
		.new_luma  (luma_s1),
		.prev_luma (prev_luma_q),
		.smoothed  (smoothed)
	);

	aels_step u_step (
		.smoothed    (smoothed),
		.target_luma (target_luma),
		.max_level   (max_level),
		.cur         (state_q),
		.nxt         (state_nxt)
	);

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign luma.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (luma.ready) begin
			valid_s1 <= luma.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (luma.ready && luma.valid) begin
			luma_s1 <= luma.frame_luma;
		end
	end

	// The loop state doubles as the result register; it only moves when the
	// previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_luma_q  <= aels_pkg::PrevLumaRst;
			state_q      <= '{level: aels_pkg::LevelRst, stable: 1'b0};
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				prev_luma_q <= smoothed;
				state_q     <= state_nxt;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.smoothed_luma  = prev_luma_q;
	assign result.exposure_level = state_q.level;
	assign result.is_stable      = state_q.stable;

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result not presented after advance");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(luma_s1)))
		else $error("input register lost a word while stalled");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !state_q.stable) |=> (state_q.level <= $past(max_level)))
		else $error("level above clamp after a non-held step");

endmodule

>>> hw/rtl/aels_cfg.sv
// ----------------------------------------------------------------------------
// aels_cfg: configuration registers
// Holds target luma and the upper level clamp, written through a plain port.
// ----------------------------------------------------------------------------
module aels_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aels_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [aels_pkg::CfgDataW-1:0]       cfg_wdata,
	output aels_pkg::luma_t                     target_luma,
	output aels_pkg::level_t                    max_level
);

	aels_pkg::luma_t  target_q;
	aels_pkg::level_t max_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= aels_pkg::TargetLumaRst;
			max_level_q <= aels_pkg::MaxLevelRst;
		end else if (cfg_we) begin
			case (aels_pkg::cfg_reg_t'(cfg_index))
				aels_pkg::REG_TARGET_LUMA: target_q    <= cfg_wdata[aels_pkg::LumaW-1:0];
				aels_pkg::REG_MAX_LEVEL:   max_level_q <= cfg_wdata[aels_pkg::LevelW-1:0];
				default: ;
			endcase
		end
	end

	assign target_luma = target_q;
	assign max_level   = max_level_q;

endmodule

>>> hw/rtl/aels_smooth.sv
// ----------------------------------------------------------------------------
// aels_smooth: jump-aware luma smoothing
// Passes large jumps through, otherwise blends 3:1 toward the new value.
// ----------------------------------------------------------------------------
module aels_smooth (
	input  aels_pkg::luma_t new_luma,
	input  aels_pkg::luma_t prev_luma,
	output aels_pkg::luma_t smoothed
);

	aels_pkg::luma_t diff;
	logic [9:0]      blend;

	always_comb begin
		diff  = (new_luma > prev_luma) ? (new_luma - prev_luma) : (prev_luma - new_luma);
		// 3*new + prev + 2 tops out at 1022, so ten bits hold it.
		blend = {2'b00, new_luma} + {1'b0, new_luma, 1'b0} + {2'b00, prev_luma}
			+ {8'd0, aels_pkg::RoundBias};
		if (diff > aels_pkg::JumpLimit) begin
			smoothed = new_luma;
		end else begin
			smoothed = blend[9:2];
		end
	end

endmodule

>>> hw/rtl/aels_step.sv
// ----------------------------------------------------------------------------
// aels_step: exposure level step rule
// Holds, or steps by a banded amount or marks stable and then clamps the level.
// ----------------------------------------------------------------------------
module aels_step (
	input  aels_pkg::luma_t      smoothed,
	input  aels_pkg::luma_t      target_luma,
	input  aels_pkg::level_t     max_level,
	input  aels_pkg::loop_state_t cur,
	output aels_pkg::loop_state_t nxt
);

	logic signed [8:0]  err;
	aels_pkg::luma_t    mag;
	logic [2:0]         step;
	logic signed [9:0]  lv;

	always_comb begin
		err = $signed({1'b0, smoothed}) - $signed({1'b0, target_luma});
		mag = err[8] ? aels_pkg::luma_t'(-err) : err[7:0];

		if (mag > aels_pkg::Band4) begin
			step = 3'd5;
		end else if (mag > aels_pkg::Band3) begin
			step = 3'd4;
		end else if (mag > aels_pkg::Band2) begin
			step = 3'd3;
		end else if (mag > aels_pkg::Band1) begin
			step = 3'd2;
		end else begin
			step = 3'd1;
		end

		lv  = $signed({2'b00, cur.level});
		nxt = cur;
		if (!(cur.stable && mag <= aels_pkg::HoldBand)) begin
			if (mag >= aels_pkg::MoveBand) begin
				// A frame brighter than target lowers the level.
				if (err[8]) begin
					lv = lv + $signed({7'd0, step});
				end else begin
					lv = lv - $signed({7'd0, step});
				end
				nxt.stable = 1'b0;
			end else begin
				nxt.stable = 1'b1;
			end
			if (lv < 0) begin
				nxt.level = '0;
			end else if (lv > $signed({2'b00, max_level})) begin
				nxt.level = max_level;
			end else begin
				nxt.level = lv[7:0];
			end
		end
	end

endmodule
